// ===== sv/fxsqrt_pkg.sv =====
// shared widths, constants and control types for the fixed-point square root
// no dependencies; imported by the controller, the datapath and the top level
package fxsqrt_pkg;

  localparam int RADICAND_W = 32;
  localparam int ROOT_W     = 16;

  // left shift applied to the radicand before the root is taken (0 to 16)
  localparam int SCALE_SHIFT = 8;

  // first trial bit of the digit recurrence
  localparam logic [RADICAND_W-1:0] FIRST_BIT = RADICAND_W'(1) << (RADICAND_W - 2);

  typedef struct packed {
    logic load;    // take a new radicand, start the recurrence
    logic step;    // one digit step
    logic unload;  // copy the finished root into the output register
  } fxsqrt_cmd_t;

  typedef struct packed {
    logic last_step;  // the step now running is the final one
  } fxsqrt_status_t;

endpackage

// ===== sv/fixed_point_square_root.sv =====
// Fixed-point square root. Each transaction on the input carries a 32-bit
// unsigned radicand; the block shifts it left by SCALE_SHIFT bits (bits past
// bit 31 are lost) and returns the floor of the square root of that 32-bit
// value as a 16-bit root. The root comes from a restoring binary
// digit-by-digit recurrence that settles one root bit per clock in a single
// add-compare-subtract unit. Each item is loaded, passed through the digit
// steps and then moved into the output register; a new radicand is not
// taken while one is in the recurrence. A finished root waits
// in its own register, so the next radicand can be taken as soon as the root
// before it has moved there. Nothing is kept between items.
// depends on fxsqrt_pkg, fxsqrt_ctrl and fxsqrt_dp
module fixed_point_square_root #(
  parameter int SCALE_SHIFT = fxsqrt_pkg::SCALE_SHIFT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fxsqrt_pkg::RADICAND_W-1:0] radicand,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fxsqrt_pkg::ROOT_W-1:0]     root
);
  import fxsqrt_pkg::*;

  fxsqrt_cmd_t    cmd;
  fxsqrt_status_t status;

  fxsqrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fxsqrt_dp #(
    .SCALE_SHIFT (SCALE_SHIFT)
  ) u_dp (
    .clk      (clk),
    .radicand (radicand),
    .cmd      (cmd),
    .status   (status),
    .root     (root)
  );

endmodule

// ===== sv/fxsqrt_ctrl.sv =====
// controller for the fixed-point square root: sequences load, sixteen digit
// steps and the hand-over to the output register; owns the output valid flag
// depends on fxsqrt_pkg
module fxsqrt_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  fxsqrt_pkg::fxsqrt_status_t status,
  output fxsqrt_pkg::fxsqrt_cmd_t    cmd
);
  import fxsqrt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       can_move;

  // output register free, or being emptied this cycle
  assign can_move = !out_valid || out_ready;

  assign in_ready   = (state == S_IDLE) || ((state == S_WAIT) && can_move);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.step   = (state == S_RUN);
  assign cmd.unload = (state == S_WAIT) && can_move;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_RUN;
      end
      S_RUN: begin
        if (status.last_step) state_next = S_WAIT;
      end
      S_WAIT: begin
        if (can_move) state_next = cmd.load ? S_RUN : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.unload) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/fxsqrt_dp.sv =====
// datapath for the fixed-point square root: remainder, root accumulator and
// trial bit of the restoring digit recurrence, plus the output register
// depends on fxsqrt_pkg
module fxsqrt_dp #(
  parameter int SCALE_SHIFT = fxsqrt_pkg::SCALE_SHIFT
) (
  input  logic                                 clk,
  input  logic [fxsqrt_pkg::RADICAND_W-1:0]    radicand,
  input  fxsqrt_pkg::fxsqrt_cmd_t              cmd,
  output fxsqrt_pkg::fxsqrt_status_t           status,
  output logic [fxsqrt_pkg::ROOT_W-1:0]        root
);
  import fxsqrt_pkg::*;

  logic [RADICAND_W-1:0] rem;
  logic [RADICAND_W-1:0] acc;
  logic [RADICAND_W-1:0] trial_bit;
  logic [RADICAND_W-1:0] trial;
  logic                  fits;

  assign trial = acc + trial_bit;
  assign fits  = (rem >= trial);

  // trial bit has reached the lowest pair
  assign status.last_step = (trial_bit[1:0] != 2'b00);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // bits pushed past the top are dropped
      rem       <= RADICAND_W'(radicand << SCALE_SHIFT);
      acc       <= '0;
      trial_bit <= FIRST_BIT;
    end else if (cmd.step) begin
      if (fits) begin
        rem <= rem - trial;
        acc <= (acc >> 1) + trial_bit;
      end else begin
        acc <= acc >> 1;
      end
      trial_bit <= trial_bit >> 2;
    end
    if (cmd.unload) begin
      root <= acc[ROOT_W-1:0];
    end
  end

endmodule

// ===== sv/fxsqrt_checker.sv =====
// port-level checks for the fixed-point square root, bound to the top level
// depends on fxsqrt_pkg and fixed_point_square_root
module fxsqrt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [fxsqrt_pkg::RADICAND_W-1:0] radicand,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [fxsqrt_pkg::ROOT_W-1:0]     root
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(root))
    else $error("result changed or dropped while stalled");

  // a waiting radicand stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(radicand))
    else $error("radicand changed or withdrawn while waiting");

  // busy right after a transaction is taken
  a_busy_next: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again during the digit recurrence");

  // still busy on the last digit step
  a_busy_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##16 !in_ready)
    else $error("input taken before the recurrence finished");

  // no result appears from nothing after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind fixed_point_square_root fxsqrt_checker u_fxsqrt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .radicand  (radicand),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .root      (root)
);

// ===== tb/sv/fxsqrt_scoreboard_pkg.sv =====
// root predictor and in-order scoreboard for the fixed-point square root testbench
// depends on fxsqrt_pkg for widths, the scale shift and the first trial bit
package fxsqrt_scoreboard_pkg;

  import fxsqrt_pkg::*;

  class root_scoreboard;

    logic [ROOT_W-1:0] expected_roots[$];
    int unsigned       errors;

    function new();
      errors = 0;
    endfunction

    // scale with wrap to 32 bits, then restoring digit-by-digit root
    static function logic [ROOT_W-1:0] floor_root(input logic [RADICAND_W-1:0] value);
      logic [RADICAND_W-1:0] rest;
      logic [RADICAND_W-1:0] acc;
      logic [RADICAND_W-1:0] probe;
      logic [RADICAND_W-1:0] trial;
      rest  = value << SCALE_SHIFT;
      acc   = '0;
      probe = FIRST_BIT;
      for (int s = 0; s < ROOT_W; s++) begin
        trial = acc + probe;
        if (rest >= trial) begin
          rest = rest - trial;
          acc  = (acc >> 1) + probe;
        end else begin
          acc = acc >> 1;
        end
        probe = probe >> 2;
      end
      return acc[ROOT_W-1:0];
    endfunction

    function void note_radicand(input logic [RADICAND_W-1:0] value);
      expected_roots.push_back(floor_root(value));
    endfunction

    function void check_root(input logic [ROOT_W-1:0] actual);
      logic [ROOT_W-1:0] want;
      if (expected_roots.size() == 0) begin
        $error("root: unexpected transaction, actual %0d", actual);
        errors++;
      end else begin
        want = expected_roots.pop_front();
        if (actual !== want) begin
          $error("root: expected %0d, actual %0d", want, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_roots.size();
    endfunction

  endclass

endpackage

// ===== tb/sv/fixed_point_square_root_tb.sv =====
// top-level testbench for fixed_point_square_root: directed corners, then bursty
// random radicands with receiver stalls; depends on fxsqrt_pkg and fxsqrt_scoreboard_pkg
module fixed_point_square_root_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import fxsqrt_pkg::*;
  import fxsqrt_scoreboard_pkg::*;

  typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned LONG_HOLD    = 400;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [RADICAND_W-1:0] radicand;
  logic                  out_valid;
  logic                  out_ready;
  logic [ROOT_W-1:0]     root;

  root_scoreboard book = new();
  int unsigned    roots_seen = 0;

  fixed_point_square_root dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .radicand  (radicand),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .root      (root)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_radicand(input logic [RADICAND_W-1:0] value);
    @(negedge clk);
    in_valid = 1'b1;
    radicand = value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_radicand(value);
  endtask

  task automatic sender_gap(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      radicand = $urandom;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic wait_all_roots();
    @(negedge clk);
    in_valid = 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  // mixes full-range values (shift wraps), unwrapped values, near perfect squares and fixed corners
  function automatic logic [RADICAND_W-1:0] pick_radicand();
    logic [RADICAND_W-1:0] r;
    int unsigned           sel;
    sel = $urandom_range(0, 9);
    r   = $urandom_range(0, 65535);
    case (sel)
      0, 1, 2: return $urandom;
      3, 4, 5: return $urandom >> (SCALE_SHIFT + $urandom_range(0, 24));
      6, 7, 8: return ((r * r) >> SCALE_SHIFT) + $urandom_range(0, 2) - 1;
      default: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return 1;
          2:       return '1;
          3:       return {RADICAND_W{1'b1}} >> SCALE_SHIFT;
          default: return ({RADICAND_W{1'b1}} >> SCALE_SHIFT) + 1;
        endcase
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      book.check_root(root);
      roots_seen++;
    end
  end

  initial begin : receiver
    rx_mode_t    mode;
    int unsigned span;
    int unsigned tick;
    bit          held;
    out_ready = 1'b0;
    tick      = 0;
    held      = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(negedge clk);
        tick++;
        // one long hold-off so the block backs up into its input
        if (!held && roots_seen >= 300) begin
          out_ready = 1'b0;
          repeat (LONG_HOLD) @(negedge clk);
          held = 1'b1;
        end
        case (mode)
          RX_ALWAYS:  out_ready = 1'b1;
          RX_COIN:    out_ready = 1'($urandom_range(0, 1));
          RX_SPARSE:  out_ready = ($urandom_range(0, 3) == 0);
          RX_CADENCE: out_ready = (tick % 4 != 0);
          default:    out_ready = 1'b1;
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [RADICAND_W-1:0] corner_cases[$];
    int unsigned           burst;
    int unsigned           sent;
    rst      = 1'b1;
    in_valid = 1'b0;
    radicand = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    corner_cases = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                     32'h0000_0004, 32'h0000_0100, 32'h0000_FFFF, 32'h0000_FF00,
                     {RADICAND_W{1'b1}} >> SCALE_SHIFT,
                     ({RADICAND_W{1'b1}} >> SCALE_SHIFT) + 1,
                     32'h0100_0001, 32'h00FF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                     32'h0000_0010, 32'h0012_3456};
    foreach (corner_cases[i]) send_radicand(corner_cases[i]);
    wait_all_roots();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 32);
      repeat (burst) begin
        send_radicand(pick_radicand());
        sent++;
        // let the block run dry once in mid-stream
        if (sent == RANDOM_ITEMS / 2) wait_all_roots();
      end
      if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 24));
    end

    wait_all_roots();
    repeat (40) @(posedge clk);
    if (book.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
